[rtl/ots_pkg.sv]
// Package for the Otsu threshold select unit.
// Holds the count and product widths, the frame limit and the fixed levels.
// No dependencies.
package ots_pkg;

	// Largest number of pixels counted in one frame; further pixels saturate.
	localparam int MAX_PIXELS = 1048576;

	localparam int LEVELS  = 256;
	localparam int LEVEL_W = 8;

	// Pixel counts reach MAX_PIXELS itself, grey sums are counts times a level.
	localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W  = CNT_W + LEVEL_W;
	localparam int PROD_W = SUM_W + CNT_W;
	localparam int DEN_W  = 2 * CNT_W;
	localparam int CAND_W = 2 * PROD_W;
	localparam int CMP_W  = CAND_W + DEN_W;

	// Shared shift-add multiplier operand widths.
	localparam int MUL_A_W = CAND_W;
	localparam int MUL_B_W = PROD_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Result when no split gives a positive variance.
	localparam logic [LEVEL_W-1:0] NO_SPLIT_LEVEL = LEVEL_W'(128);
	localparam logic [LEVEL_W-1:0] LAST_LEVEL     = LEVEL_W'(LEVELS - 1);

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [SUM_W-1:0] sum_t;

endpackage

[rtl/ots_pix_if.sv]
// Pixel channel of the Otsu threshold select unit.
// Depends on ots_pkg for the level width.
interface ots_pix_if;
	logic                         valid;
	logic                         ready;
	logic [ots_pkg::LEVEL_W-1:0]  pixel;
	logic                         last_pixel;

	modport source(output valid, pixel, last_pixel, input ready);
	modport sink(input valid, pixel, last_pixel, output ready);
endinterface

[rtl/ots_thr_if.sv]
// Threshold result channel of the Otsu threshold select unit.
// Depends on ots_pkg for the level width.
interface ots_thr_if;
	logic                         valid;
	logic                         ready;
	logic [ots_pkg::LEVEL_W-1:0]  threshold;

	modport source(output valid, threshold, input ready);
	modport sink(input valid, threshold, output ready);
endinterface

[rtl/ots_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ots_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/ots_mul.sv]
// Shared shift-add multiplier: one multiplier bit and one wide add per cycle.
// Depends on ots_pkg for the operand widths.
module ots_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ots_pkg::MUL_A_W-1:0]   a,
	input  logic [ots_pkg::MUL_B_W-1:0]   b,
	output logic                          done,
	output logic [ots_pkg::MUL_P_W-1:0]   p
);

	logic                          busy_q;
	logic [ots_pkg::MUL_P_W-1:0]   acc_q;
	logic [ots_pkg::MUL_P_W-1:0]   a_q;
	logic [ots_pkg::MUL_B_W-1:0]   b_q;

	// The product is complete once no multiplier bits remain.
	assign done = busy_q && (b_q == '0);
	assign p    = acc_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// Datapath: add the shifted multiplicand for each set multiplier bit.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= ots_pkg::MUL_P_W'(a);
			b_q   <= b;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

endmodule

[rtl/otsu_threshold_select_unit.sv]
// Otsu threshold select unit: top level with the histogram and the search sequencer.
// Depends on ots_pkg, ots_pix_if, ots_thr_if, ots_ram and ots_mul.
//
// Use: grey pixels arrive as beats on the pix channel, the final pixel of a
// frame flagged by last_pixel. Each pixel beat reads its histogram bin and
// then writes it back incremented; pix.ready is low during the write-back.
// Once MAX_PIXELS pixels are counted, further pixels are taken but not
// counted. After the last pixel the unit scans all 256 thresholds. Each
// threshold passes the SRD, SACC, CHK and NEXT bookkeeping states plus,
// where both classes are non-empty, six products on the shared shift-add
// multiplier, each of which runs until the significant bits of its second
// operand are used up. The threshold is then held on thr as one beat until
// the receiver takes it; pix stays not ready while it waits. Taking the beat
// clears the histogram and all accumulators. Reset clears the histogram
// valid bits at once, so no clearing pass runs and the unit is ready as
// soon as reset is released.
module otsu_threshold_select_unit (
	input logic           clk,
	input logic           arst_n,
	ots_pix_if.sink       pix,
	ots_thr_if.source     thr
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PINC = 4'd1;
	localparam logic [3:0] ST_SRD  = 4'd2;
	localparam logic [3:0] ST_SACC = 4'd3;
	localparam logic [3:0] ST_CHK  = 4'd4;
	localparam logic [3:0] ST_MA   = 4'd5;
	localparam logic [3:0] ST_MB   = 4'd6;
	localparam logic [3:0] ST_MD   = 4'd7;
	localparam logic [3:0] ST_ML   = 4'd8;
	localparam logic [3:0] ST_MN   = 4'd9;
	localparam logic [3:0] ST_MR   = 4'd10;
	localparam logic [3:0] ST_NEXT = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	logic [3:0]                        state_q;
	logic [ots_pkg::LEVELS-1:0]        vld_q;
	logic [ots_pkg::LEVEL_W-1:0]       pix_q;
	logic                              last_q;
	logic                              cnt_ok_q;
	logic [ots_pkg::LEVEL_W-1:0]       t_q;
	ots_pkg::cnt_t                     total_q;
	ots_pkg::sum_t                     wt_q;
	ots_pkg::cnt_t                     wb_q;
	ots_pkg::sum_t                     sb_q;
	ots_pkg::cnt_t                     wf_q;
	ots_pkg::sum_t                     sf_q;
	logic [ots_pkg::PROD_W-1:0]        a_q;
	logic [ots_pkg::CAND_W-1:0]        cand_q;
	logic [ots_pkg::CMP_W-1:0]         left_q;
	logic [ots_pkg::DEN_W-1:0]         den_q;
	logic [ots_pkg::CAND_W-1:0]        bn_q;
	logic [ots_pkg::DEN_W-1:0]         bd_q;
	logic [ots_pkg::LEVEL_W-1:0]       best_q;

	logic                              ram_we;
	logic [ots_pkg::CNT_W-1:0]         ram_wdata;
	logic [ots_pkg::LEVEL_W-1:0]       ram_raddr;
	logic [ots_pkg::CNT_W-1:0]         ram_rdata;
	logic [ots_pkg::CNT_W-1:0]         bin_cnt;
	logic [ots_pkg::LEVEL_W-1:0]       bin_idx;

	logic                              mul_start;
	logic [ots_pkg::MUL_A_W-1:0]       mul_a;
	logic [ots_pkg::MUL_B_W-1:0]       mul_b;
	logic                              mul_done;
	logic [ots_pkg::MUL_P_W-1:0]       mul_p;

	ots_pkg::cnt_t                     wf_c;
	logic [ots_pkg::PROD_W-1:0]        prod_lo;
	logic [ots_pkg::PROD_W-1:0]        diff_c;
	logic                              pix_acc;
	logic                              thr_acc;
	logic                              greater;

	assign pix.ready     = (state_q == ST_IDLE);
	assign thr.valid     = (state_q == ST_OUT);
	assign thr.threshold = best_q;
	assign pix_acc       = pix.valid && pix.ready;
	assign thr_acc       = thr.valid && thr.ready;

	// Histogram storage; a bin whose valid bit is clear reads as zero.
	ots_ram #(
		.WIDTH(ots_pkg::CNT_W),
		.DEPTH(ots_pkg::LEVELS)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pix_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ram_raddr = (state_q == ST_SRD) ? t_q : pix.pixel;
	assign bin_idx   = (state_q == ST_PINC) ? pix_q : t_q;
	assign bin_cnt   = vld_q[bin_idx] ? ram_rdata : '0;
	assign ram_we    = (state_q == ST_PINC) && cnt_ok_q;
	assign ram_wdata = bin_cnt + ots_pkg::CNT_W'(1);

	// Shared multiplier.
	ots_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.p     (mul_p)
	);

	// Class terms and the absolute difference of the two cross products.
	assign wf_c    = total_q - wb_q;
	assign prod_lo = mul_p[ots_pkg::PROD_W-1:0];
	assign diff_c  = (a_q >= prod_lo) ? (a_q - prod_lo) : (prod_lo - a_q);
	assign greater = left_q > mul_p[ots_pkg::CMP_W-1:0];

	// Operand selection: each finished product starts the next one.
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_CHK: begin
				mul_start = (wb_q != '0) && (wb_q < total_q);
				mul_a     = ots_pkg::MUL_A_W'(sb_q);
				mul_b     = ots_pkg::MUL_B_W'(wf_c);
			end
			ST_MA: begin
				mul_start = mul_done;
				mul_a     = ots_pkg::MUL_A_W'(sf_q);
				mul_b     = ots_pkg::MUL_B_W'(wb_q);
			end
			ST_MB: begin
				mul_start = mul_done;
				mul_a     = ots_pkg::MUL_A_W'(diff_c);
				mul_b     = diff_c;
			end
			ST_MD: begin
				mul_start = mul_done;
				mul_a     = mul_p[ots_pkg::CAND_W-1:0];
				mul_b     = ots_pkg::MUL_B_W'(bd_q);
			end
			ST_ML: begin
				mul_start = mul_done;
				mul_a     = ots_pkg::MUL_A_W'(wb_q);
				mul_b     = ots_pkg::MUL_B_W'(wf_q);
			end
			ST_MN: begin
				mul_start = mul_done;
				mul_a     = bn_q;
				mul_b     = ots_pkg::MUL_B_W'(mul_p[ots_pkg::DEN_W-1:0]);
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// Sequencer and histogram valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			vld_q    <= '0;
			last_q   <= 1'b0;
			cnt_ok_q <= 1'b0;
			t_q      <= '0;
			total_q  <= '0;
			wt_q     <= '0;
			wb_q     <= '0;
			sb_q     <= '0;
			bn_q     <= '0;
			bd_q     <= ots_pkg::DEN_W'(1);
			best_q   <= ots_pkg::NO_SPLIT_LEVEL;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pix_acc) begin
						last_q   <= pix.last_pixel;
						cnt_ok_q <= total_q < ots_pkg::CNT_W'(ots_pkg::MAX_PIXELS);
						state_q  <= ST_PINC;
					end
				end
				ST_PINC: begin
					if (cnt_ok_q) begin
						vld_q[pix_q] <= 1'b1;
						total_q      <= total_q + ots_pkg::CNT_W'(1);
						wt_q         <= wt_q + ots_pkg::SUM_W'(pix_q);
					end
					t_q     <= '0;
					wb_q    <= '0;
					sb_q    <= '0;
					state_q <= last_q ? ST_SRD : ST_IDLE;
				end
				ST_SRD: begin
					state_q <= ST_SACC;
				end
				ST_SACC: begin
					wb_q    <= wb_q + bin_cnt;
					sb_q    <= sb_q + ots_pkg::SUM_W'(t_q) * ots_pkg::SUM_W'(bin_cnt);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= mul_start ? ST_MA : ST_NEXT;
				end
				ST_MA: begin
					if (mul_done) begin
						state_q <= ST_MB;
					end
				end
				ST_MB: begin
					if (mul_done) begin
						state_q <= ST_MD;
					end
				end
				ST_MD: begin
					if (mul_done) begin
						state_q <= ST_ML;
					end
				end
				ST_ML: begin
					if (mul_done) begin
						state_q <= ST_MN;
					end
				end
				ST_MN: begin
					if (mul_done) begin
						state_q <= ST_MR;
					end
				end
				ST_MR: begin
					if (mul_done) begin
						if (greater) begin
							bn_q   <= cand_q;
							bd_q   <= den_q;
							best_q <= t_q;
						end
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (t_q == ots_pkg::LAST_LEVEL) begin
						state_q <= ST_OUT;
					end else begin
						t_q     <= t_q + ots_pkg::LEVEL_W'(1);
						state_q <= ST_SRD;
					end
				end
				ST_OUT: begin
					// The result beat leaves and the frame state returns to reset values.
					if (thr_acc) begin
						vld_q   <= '0;
						total_q <= '0;
						wt_q    <= '0;
						wb_q    <= '0;
						sb_q    <= '0;
						t_q     <= '0;
						bn_q    <= '0;
						bd_q    <= ots_pkg::DEN_W'(1);
						best_q  <= ots_pkg::NO_SPLIT_LEVEL;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: pixel under update and the terms of the current threshold.
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_q <= pix.pixel;
		end
		if (state_q == ST_CHK) begin
			wf_q <= wf_c;
			sf_q <= wt_q - sb_q;
		end
		if (mul_done) begin
			unique case (state_q)
				ST_MA:   a_q    <= prod_lo;
				ST_MD:   cand_q <= mul_p[ots_pkg::CAND_W-1:0];
				ST_ML:   left_q <= mul_p[ots_pkg::CMP_W-1:0];
				ST_MN:   den_q  <= mul_p[ots_pkg::DEN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
